>>> rtl/core/scm_pkg.sv
// Shared types, constants and helper functions for the session chunker block.
`default_nettype none

package scm_pkg;

  localparam int unsigned NUM_LANES   = 6;
  localparam int unsigned FEAT_W      = 16;
  localparam int unsigned LABEL_W     = 16;
  localparam int unsigned SESS_W      = 32;
  localparam int unsigned INDEX_W     = 16;
  localparam int unsigned WIN_W       = 11;
  localparam int unsigned PIC_W       = 6;
  localparam int unsigned NF_W        = 3;
  localparam int unsigned TGT_W       = 6;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 11;

  localparam logic [WIN_W-1:0] MAX_WINDOW      = 11'd1024;
  localparam logic [PIC_W-1:0] MAX_PREDICTIONS = 6'd32;
  localparam logic [NF_W-1:0]  MAX_LANES       = 3'd6;

  localparam int unsigned IN_DATA_W  = 144;
  localparam int unsigned OUT_DATA_W = 168;

  localparam int unsigned IN_LABEL_LSB  = SESS_W;
  localparam int unsigned IN_FEAT_LSB   = SESS_W + LABEL_W;
  localparam int unsigned OUT_SESS_LSB  = INDEX_W;
  localparam int unsigned OUT_LABEL_LSB = INDEX_W + SESS_W;
  localparam int unsigned OUT_WT_BIT    = INDEX_W + SESS_W + LABEL_W;
  localparam int unsigned OUT_FEAT_LSB  = OUT_WT_BIT + 1;

  typedef enum logic [1:0] {
    KIND_SAMPLE    = 2'd0,
    KIND_TARGET    = 2'd1,
    KIND_CHUNK_END = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRED_WINDOW = 2'd0,
    CFG_PRED_CHUNK  = 2'd1,
    CFG_NUM_FEAT    = 2'd2,
    CFG_USE_TARGET  = 2'd3
  } cfg_idx_e;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ECHO = 6'b000010,
    S_WTGT = 6'b000100,
    S_CTGT = 6'b001000,
    S_CPAD = 6'b010000,
    S_CEND = 6'b100000
  } state_e;

  typedef logic signed [FEAT_W-1:0] feat_t;

  typedef struct packed {
    logic upd;
    logic clr;
  } vote_cmd_t;

  typedef struct packed {
    logic [LABEL_W-1:0] cand;
    logic               nonempty;
    logic               full;
  } vote_stat_t;

  function automatic logic [WIN_W-1:0] clamp_pw(input logic [WIN_W-1:0] v);
    logic [WIN_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = WIN_W'(1);
    end else if (v > MAX_WINDOW) begin
      r = MAX_WINDOW;
    end
    return r;
  endfunction

  function automatic logic [PIC_W-1:0] clamp_pic(input logic [PIC_W-1:0] v);
    logic [PIC_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = PIC_W'(1);
    end else if (v > MAX_PREDICTIONS) begin
      r = MAX_PREDICTIONS;
    end
    return r;
  endfunction

  function automatic logic [NF_W-1:0] clamp_nf(input logic [NF_W-1:0] v);
    logic [NF_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = NF_W'(1);
    end else if (v > MAX_LANES) begin
      r = MAX_LANES;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/scm_vote.sv
// Streaming majority vote unit that tracks one prediction window.
`default_nettype none

module scm_vote
  import scm_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire vote_cmd_t          cmd_i,
  input  wire logic [LABEL_W-1:0] label_i,
  input  wire logic [WIN_W-1:0]   pw_i,
  output vote_stat_t              stat_o
);

  logic [LABEL_W-1:0] cand_q, cand_d;
  logic [WIN_W-1:0]   cnt_q, cnt_d;
  logic [WIN_W-1:0]   wsc_q, wsc_d;
  logic [WIN_W:0]     wsc_inc;

  assign wsc_inc = {1'b0, wsc_q} + (WIN_W + 1)'(1);

  always_comb begin
    cand_d = cand_q;
    cnt_d  = cnt_q;
    wsc_d  = wsc_q;
    if (cmd_i.clr) begin
      cand_d = '0;
      cnt_d  = '0;
      wsc_d  = '0;
    end else if (cmd_i.upd) begin
      if (cnt_q == '0) begin
        cand_d = label_i;
        cnt_d  = WIN_W'(1);
      end else if (cand_q == label_i) begin
        cnt_d = cnt_q + WIN_W'(1);
      end else begin
        cnt_d = cnt_q - WIN_W'(1);
      end
      wsc_d = wsc_inc[WIN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q <= '0;
      cnt_q  <= '0;
      wsc_q  <= '0;
    end else begin
      cand_q <= cand_d;
      cnt_q  <= cnt_d;
      wsc_q  <= wsc_d;
    end
  end

  assign stat_o.cand     = cand_q;
  assign stat_o.nonempty = (wsc_q != '0);
  assign stat_o.full     = (wsc_inc >= {1'b0, pw_i});

endmodule

`default_nettype wire

>>> rtl/core/session_chunker_majority_label_top.sv
// Top level of the session chunker with windowed majority labels.
//
// Samples enter on the s_axis channel (tuser is the op: sample or flush) and
// results leave on the m_axis channel (tuser is the kind, tlast marks the last
// result of one input transaction). Configuration is written through the
// cfg_we_i/cfg_idx_i/cfg_data_i port; the user must write it only while the
// block is idle, which the block itself does not enforce. One input transaction
// is taken at a time: s_axis_tready is high only while the sequencer is idle.
// A sample yields its echo from the S_ECHO state, followed by a window target
// and a chunk close when due. A chunk close emits at most one result per cycle
// while the receiver does not stall: the partial window target, the padding
// targets and the chunk-end item; S_CTGT moves on without output when no
// partial target is due, and S_CPAD does so when the padding loop ends.
// Every result passes through a single output register; while the receiver
// stalls, a state with a result to emit waits on that register and holds.
// After reset the configuration is window 1, one window per chunk, six
// feature lanes and labels in use, with no open chunk or session.
`default_nettype none

module session_chunker_majority_label_top
  import scm_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output      logic                  s_axis_tready,
  // session, label, feature_0 .. feature_5
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // op
  input  wire logic                  s_axis_tuser,
  output      logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // index, out_session, target_label, weight, out_feature_0 .. out_feature_5, zero fill
  output      logic [OUT_DATA_W-1:0] m_axis_tdata,
  // kind
  output      logic [1:0]            m_axis_tuser,
  output      logic                  m_axis_tlast,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [WIN_W-1:0]   pw_q;
  logic [PIC_W-1:0]   pic_q;
  logic [NF_W-1:0]    nf_q;
  logic               ut_q;
  logic [INDEX_W-1:0] csize_q;

  logic [WIN_W-1:0]   pw_cl;
  logic [PIC_W-1:0]   pic_cl;
  logic [NF_W-1:0]    nf_cl;
  logic [WIN_W+PIC_W-1:0] csize_full;

  state_e             state_q, state_d;
  logic               ret_q, ret_d;
  logic               cfull_q, cfull_d;
  logic               have_q, have_d;
  logic [SESS_W-1:0]  cur_q, cur_d;
  logic [INDEX_W-1:0] csc_q, csc_d;
  logic [TGT_W-1:0]   te_q, te_d;

  logic [SESS_W-1:0]  sess_q;
  logic [LABEL_W-1:0] label_q;
  feat_t              feat_q [NUM_LANES];

  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic [1:0]            out_user_q;
  logic                  out_last_q;

  vote_cmd_t  vcmd;
  vote_stat_t vstat;

  logic               accept;
  logic               out_free;
  logic               emit;
  logic               fire;
  kind_e              o_kind;
  logic               o_last;
  logic [INDEX_W-1:0] o_index;
  logic [SESS_W-1:0]  o_sess;
  logic [LABEL_W-1:0] o_label;
  logic               o_weight;
  logic               o_feat_en;
  logic [OUT_DATA_W-1:0] o_data;
  logic [INDEX_W-1:0] csc_inc;
  logic [TGT_W-1:0]   te_inc;
  logic               cfull_now;
  logic               wfull_now;

  assign pw_cl      = clamp_pw(pw_q);
  assign pic_cl     = clamp_pic(pic_q);
  assign nf_cl      = clamp_nf(nf_q);
  assign csize_full = pw_cl * pic_cl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw_q    <= WIN_W'(1);
      pic_q   <= PIC_W'(1);
      nf_q    <= MAX_LANES;
      ut_q    <= 1'b1;
      csize_q <= INDEX_W'(1);
    end else begin
      csize_q <= csize_full[INDEX_W-1:0];
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PRED_WINDOW: pw_q  <= cfg_data_i[WIN_W-1:0];
          CFG_PRED_CHUNK:  pic_q <= cfg_data_i[PIC_W-1:0];
          CFG_NUM_FEAT:    nf_q  <= cfg_data_i[NF_W-1:0];
          CFG_USE_TARGET:  ut_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign fire          = emit && out_free;

  assign csc_inc   = (csc_q != '1) ? csc_q + INDEX_W'(1) : csc_q;
  assign te_inc    = (te_q != '1) ? te_q + TGT_W'(1) : te_q;
  assign cfull_now = (csc_inc >= csize_q);
  assign wfull_now = ut_q && vstat.full;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sess_q  <= s_axis_tdata[SESS_W-1:0];
      label_q <= s_axis_tdata[IN_LABEL_LSB +: LABEL_W];
      for (int k = 0; k < NUM_LANES; k++) begin
        feat_q[k] <= s_axis_tdata[IN_FEAT_LSB + k*FEAT_W +: FEAT_W];
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    cfull_d   = cfull_q;
    have_d    = have_q;
    cur_d     = cur_q;
    csc_d     = csc_q;
    te_d      = te_q;
    emit      = 1'b0;
    o_kind    = KIND_SAMPLE;
    o_last    = 1'b0;
    o_index   = '0;
    o_sess    = cur_q;
    o_label   = '0;
    o_weight  = 1'b0;
    o_feat_en = 1'b0;
    vcmd      = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (s_axis_tuser == OP_FLUSH) begin
            if (csc_q != '0) begin
              ret_d   = 1'b0;
              state_d = S_CTGT;
            end
          end else if (have_q && (s_axis_tdata[SESS_W-1:0] != cur_q) && (csc_q != '0)) begin
            ret_d   = 1'b1;
            state_d = S_CTGT;
          end else begin
            state_d = S_ECHO;
          end
        end
      end
      S_ECHO: begin
        emit      = 1'b1;
        o_kind    = KIND_SAMPLE;
        o_index   = csc_q;
        o_sess    = sess_q;
        o_feat_en = 1'b1;
        o_last    = !wfull_now && !cfull_now;
        if (fire) begin
          have_d   = 1'b1;
          cur_d    = sess_q;
          csc_d    = csc_inc;
          cfull_d  = cfull_now;
          vcmd.upd = ut_q;
          vcmd.clr = !ut_q;
          ret_d    = 1'b0;
          if (wfull_now) begin
            state_d = S_WTGT;
          end else if (cfull_now) begin
            state_d = S_CTGT;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_WTGT: begin
        emit     = 1'b1;
        o_kind   = KIND_TARGET;
        o_index  = INDEX_W'(te_q);
        o_label  = vstat.cand;
        o_weight = 1'b1;
        o_last   = !cfull_q;
        if (fire) begin
          te_d     = te_inc;
          vcmd.clr = 1'b1;
          state_d  = cfull_q ? S_CTGT : S_IDLE;
        end
      end
      S_CTGT: begin
        if (ut_q && vstat.nonempty) begin
          emit     = 1'b1;
          o_kind   = KIND_TARGET;
          o_index  = INDEX_W'(te_q);
          o_label  = vstat.cand;
          o_weight = 1'b1;
          if (fire) begin
            te_d    = te_inc;
            state_d = S_CPAD;
          end
        end else begin
          state_d = S_CPAD;
        end
      end
      S_CPAD: begin
        if (ut_q && (te_q < TGT_W'(pic_cl))) begin
          emit    = 1'b1;
          o_kind  = KIND_TARGET;
          o_index = INDEX_W'(te_q);
          if (fire) begin
            te_d = te_inc;
          end
        end else begin
          state_d = S_CEND;
        end
      end
      S_CEND: begin
        emit    = 1'b1;
        o_kind  = KIND_CHUNK_END;
        o_index = csc_q;
        o_last  = !ret_q;
        if (fire) begin
          vcmd.clr = 1'b1;
          csc_d    = '0;
          te_d     = '0;
          state_d  = ret_q ? S_ECHO : S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    o_data = '0;
    o_data[INDEX_W-1:0]                = o_index;
    o_data[OUT_SESS_LSB +: SESS_W]     = o_sess;
    o_data[OUT_LABEL_LSB +: LABEL_W]   = o_label;
    o_data[OUT_WT_BIT]                 = o_weight;
    for (int k = 0; k < NUM_LANES; k++) begin
      if (o_feat_en && (NF_W'(k) < nf_cl)) begin
        o_data[OUT_FEAT_LSB + k*FEAT_W +: FEAT_W] = feat_q[k];
      end
    end
  end

  scm_vote u_vote (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (vcmd),
    .label_i (label_q),
    .pw_i    (pw_cl),
    .stat_o  (vstat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= 1'b0;
      cfull_q <= 1'b0;
      have_q  <= 1'b0;
      cur_q   <= '0;
      csc_q   <= '0;
      te_q    <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      cfull_q <= cfull_d;
      have_q  <= have_d;
      cur_q   <= cur_d;
      csc_q   <= csc_d;
      te_q    <= te_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= o_data;
      out_user_q <= o_kind;
      out_last_q <= o_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

>>> verif/tb_session_chunker_majority_label_top.sv
// Testbench for the session chunker: directed and random streams checked against a predictor.
`default_nettype none

module tb_session_chunker_majority_label_top;
  import scm_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned SETTLE_TICKS = 8;
  localparam int unsigned END_TICKS    = 20;
  localparam int unsigned RAND_PHASES  = 5;
  localparam int unsigned PHASE_ITEMS  = 57;

  typedef struct packed {
    logic                             op;
    logic [SESS_W-1:0]                sess;
    logic [LABEL_W-1:0]               label;
    logic [NUM_LANES-1:0][FEAT_W-1:0] feat;
  } in_item_t;

  typedef struct packed {
    kind_e                            kind;
    logic                             last;
    logic [INDEX_W-1:0]               index;
    logic [SESS_W-1:0]                sess;
    logic [LABEL_W-1:0]               label;
    logic                             weight;
    logic [NUM_LANES-1:0][FEAT_W-1:0] feat;
  } result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = OP_SAMPLE;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0]            m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = CFG_PRED_WINDOW;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  session_chunker_majority_label_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor copy of the configuration registers and the chunking state.
  logic [WIN_W-1:0]   win_len_reg = WIN_W'(1);
  logic [PIC_W-1:0]   win_per_chunk_reg = PIC_W'(1);
  logic [NF_W-1:0]    lanes_reg = NF_W'(6);
  logic               labels_on_reg = 1'b1;
  logic               sess_valid = 1'b0;
  logic [SESS_W-1:0]  sess_cur = '0;
  logic [INDEX_W-1:0] chunk_fill = '0;
  logic [WIN_W-1:0]   win_fill = '0;
  logic [LABEL_W-1:0] vote_label = '0;
  logic [WIN_W-1:0]   vote_count = '0;
  logic [TGT_W-1:0]   tgt_slot = '0;

  result_t expected_results[$];
  int      fail_count = 0;
  int      cycle_count = 0;
  bit      gaps_on = 1'b0;
  bit      stalls_on = 1'b0;
  int      ready_hold = 0;

  function automatic int unsigned clamp_reg(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    return $urandom_range(6, 20);
  endfunction

  function automatic void add_expected(kind_e k, logic [INDEX_W-1:0] idx,
                                       logic [SESS_W-1:0] s, logic [LABEL_W-1:0] lab,
                                       logic wt, logic [NUM_LANES-1:0][FEAT_W-1:0] f);
    result_t r;
    r.kind   = k;
    r.last   = 1'b0;
    r.index  = idx;
    r.sess   = s;
    r.label  = lab;
    r.weight = wt;
    r.feat   = f;
    expected_results = {expected_results, r};
  endfunction

  function automatic void count_target();
    if (tgt_slot < TGT_W'(63)) tgt_slot = tgt_slot + 1'b1;
  endfunction

  function automatic void clear_vote();
    win_fill   = '0;
    vote_label = '0;
    vote_count = '0;
  endfunction

  function automatic void predict_chunk_close();
    int unsigned slots;
    slots = clamp_reg(win_per_chunk_reg, 32);
    if (labels_on_reg) begin
      if (win_fill != 0) begin
        add_expected(KIND_TARGET, INDEX_W'(tgt_slot), sess_cur, vote_label, 1'b1, '0);
        count_target();
      end
      while (tgt_slot < slots) begin
        add_expected(KIND_TARGET, INDEX_W'(tgt_slot), sess_cur, '0, 1'b0, '0);
        count_target();
      end
    end
    add_expected(KIND_CHUNK_END, chunk_fill, sess_cur, '0, 1'b0, '0);
    clear_vote();
    chunk_fill = '0;
    tgt_slot   = '0;
  endfunction

  function automatic void predict_results(in_item_t it);
    int unsigned                      win, slots, lanes, chunk_cap, n0;
    logic [NUM_LANES-1:0][FEAT_W-1:0] f;
    n0        = expected_results.size();
    win       = clamp_reg(win_len_reg, 1024);
    slots     = clamp_reg(win_per_chunk_reg, 32);
    lanes     = clamp_reg(lanes_reg, NUM_LANES);
    chunk_cap = win * slots;
    if (it.op == OP_FLUSH) begin
      if (chunk_fill != 0) predict_chunk_close();
    end else begin
      if (sess_valid && it.sess != sess_cur && chunk_fill != 0) predict_chunk_close();
      sess_valid = 1'b1;
      sess_cur   = it.sess;
      for (int k = 0; k < NUM_LANES; k++) f[k] = (k < lanes) ? it.feat[k] : '0;
      add_expected(KIND_SAMPLE, chunk_fill, it.sess, '0, 1'b0, f);
      if (labels_on_reg) begin
        if (vote_count == 0) begin
          vote_label = it.label;
          vote_count = WIN_W'(1);
        end else if (vote_label == it.label) begin
          vote_count = vote_count + 1'b1;
        end else begin
          vote_count = vote_count - 1'b1;
        end
        win_fill = win_fill + 1'b1;
        if (win_fill >= win) begin
          add_expected(KIND_TARGET, INDEX_W'(tgt_slot), it.sess, vote_label, 1'b1, '0);
          count_target();
          clear_vote();
        end
      end else begin
        clear_vote();
      end
      if (chunk_fill != 16'hFFFF) chunk_fill = chunk_fill + 1'b1;
      if (chunk_fill >= chunk_cap) predict_chunk_close();
    end
    if (expected_results.size() > n0) expected_results[expected_results.size() - 1].last = 1'b1;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $error("Result with nothing expected: kind %0d index %0d", m_axis_tuser,
               m_axis_tdata[INDEX_W-1:0]);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("kind", want.kind, m_axis_tuser);
        check_field("last", want.last, m_axis_tlast);
        check_field("index", want.index, m_axis_tdata[INDEX_W-1:0]);
        check_field("out_session", want.sess, m_axis_tdata[OUT_SESS_LSB +: SESS_W]);
        check_field("target_label", want.label, m_axis_tdata[OUT_LABEL_LSB +: LABEL_W]);
        check_field("weight", want.weight, m_axis_tdata[OUT_WT_BIT]);
        for (int k = 0; k < NUM_LANES; k++) begin
          check_field($sformatf("out_feature_%0d", k), want.feat[k],
                      m_axis_tdata[OUT_FEAT_LSB + k*FEAT_W +: FEAT_W]);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (!stalls_on) begin
      m_axis_tready <= 1'b1;
      ready_hold    <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      m_axis_tready <= ~m_axis_tready;
      ready_hold    <= pick_gap();
    end
  end

  function automatic in_item_t make_sample(logic [SESS_W-1:0] s, logic [LABEL_W-1:0] lab);
    in_item_t it;
    it.op    = OP_SAMPLE;
    it.sess  = s;
    it.label = lab;
    for (int k = 0; k < NUM_LANES; k++) it.feat[k] = FEAT_W'($urandom());
    return it;
  endfunction

  // Entered and left at a falling edge; tvalid stays high when the next transaction follows at once.
  task automatic send_item(in_item_t it);
    int unsigned gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.op;
    s_axis_tdata  <= {it.feat, it.label, it.sess};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_results(it);
    @(negedge clk_i);
  endtask

  task automatic send_sample(logic [SESS_W-1:0] s, logic [LABEL_W-1:0] lab);
    send_item(make_sample(s, lab));
  endtask

  task automatic send_flush();
    in_item_t it;
    it    = make_sample($urandom(), LABEL_W'($urandom()));
    it.op = OP_FLUSH;
    send_item(it);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_TICKS) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int unsigned val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_DATA_W'(val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    case (idx)
      CFG_PRED_WINDOW: win_len_reg = WIN_W'(val);
      CFG_PRED_CHUNK:  win_per_chunk_reg = PIC_W'(val);
      CFG_NUM_FEAT:    lanes_reg = NF_W'(val);
      CFG_USE_TARGET:  labels_on_reg = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(int unsigned win, int unsigned slots, int unsigned lanes,
                            int unsigned labels_on);
    wait_idle();
    write_reg(CFG_PRED_WINDOW, win);
    write_reg(CFG_PRED_CHUNK, slots);
    write_reg(CFG_NUM_FEAT, lanes);
    write_reg(CFG_USE_TARGET, labels_on);
  endtask

  function automatic int unsigned pick_reg_value(cfg_idx_e idx);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (idx)
      CFG_PRED_WINDOW: begin
        if (r < 60) return $urandom_range(1, 4);
        if (r < 80) return $urandom_range(5, 16);
        case ($urandom_range(0, 3))
          0: return 0;
          1: return 1023;
          2: return 1024;
          default: return 2047;
        endcase
      end
      CFG_PRED_CHUNK: begin
        if (r < 70) return $urandom_range(1, 4);
        if (r < 85) return $urandom_range(5, 8);
        case ($urandom_range(0, 3))
          0: return 0;
          1: return 31;
          2: return 32;
          default: return 63;
        endcase
      end
      CFG_NUM_FEAT: return $urandom_range(0, 7);
      default: return (r < 80) ? 1 : 0;
    endcase
  endfunction

  // Reset configuration: every sample is its own window and its own chunk.
  task automatic test_reset_state();
    in_item_t it;
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    send_flush();
    it      = make_sample('0, '0);
    it.feat = {NUM_LANES{16'h8000}};
    send_item(it);
    it      = make_sample(32'hFFFF_FFFF, 16'hFFFF);
    it.feat = {NUM_LANES{16'h7FFF}};
    send_item(it);
    send_flush();
  endtask

  task automatic test_window_votes();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    set_config(3, 4, 3, 1);
    send_sample(32'd10, 16'd5);
    send_sample(32'd10, 16'd6);
    send_sample(32'd10, 16'd5);
    send_sample(32'd10, 16'd7);
    send_sample(32'd10, 16'd8);
    send_sample(32'd10, 16'd9);
    send_sample(32'd10, 16'd4);
    send_flush();
    send_sample(32'd11, 16'd1);
    send_sample(32'd12, 16'd2);
  endtask

  task automatic test_config_mid_chunk();
    set_config(4, 4, 6, 1);
    send_sample(32'd20, 16'd1);
    send_sample(32'd20, 16'd1);
    send_sample(32'd20, 16'd2);
    wait_idle();
    write_reg(CFG_PRED_WINDOW, 2);
    send_sample(32'd20, 16'd2);
    wait_idle();
    write_reg(CFG_PRED_CHUNK, 1);
    send_sample(32'd20, 16'd3);
    wait_idle();
    write_reg(CFG_USE_TARGET, 0);
    send_sample(32'd20, 16'd3);
    send_sample(32'd20, 16'd4);
  endtask

  task automatic test_register_limits();
    set_config(2047, 63, 7, 1);
    send_sample(32'd5, 16'd9);
    send_flush();
    set_config(0, 0, 0, 0);
    send_sample(32'd6, 16'd9);
    send_flush();
  endtask

  task automatic test_random_stream();
    int unsigned       sent, run_len, r;
    logic [SESS_W-1:0] s;
    logic [LABEL_W-1:0] dom, lab;
    in_item_t          it;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      gaps_on   = (ph != 0);
      stalls_on = (ph != 0);
      set_config(pick_reg_value(CFG_PRED_WINDOW), pick_reg_value(CFG_PRED_CHUNK),
                 pick_reg_value(CFG_NUM_FEAT), pick_reg_value(CFG_USE_TARGET));
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) begin
          wait_idle();
          r = $urandom_range(0, 3);
          write_reg(cfg_idx_e'(r), pick_reg_value(cfg_idx_e'(r)));
        end
        s       = ($urandom_range(0, 9) < 7) ? SESS_W'($urandom_range(1, 3)) : $urandom();
        dom     = ($urandom_range(0, 9) == 0) ? LABEL_W'($urandom())
                                              : LABEL_W'($urandom_range(0, 3));
        run_len = $urandom_range(1, 12);
        for (int i = 0; i < run_len && sent < PHASE_ITEMS; i++) begin
          r = $urandom_range(0, 9);
          if (r < 6) lab = dom;
          else if (r < 9) lab = LABEL_W'($urandom_range(0, 3));
          else lab = LABEL_W'($urandom());
          it = make_sample(s, lab);
          if ($urandom_range(0, 19) == 0) it.op = OP_FLUSH;
          send_item(it);
          sent++;
        end
        if ($urandom_range(0, 3) == 0 && sent < PHASE_ITEMS) begin
          send_flush();
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_state();
    test_window_votes();
    test_config_mid_chunk();
    test_register_limits();
    test_random_stream();
    wait_idle();
    repeat (END_TICKS) @(negedge clk_i);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
